### rtl/fmr_pkg.sv
// fmr_pkg: widths, transaction types and controller/datapath interface structs
// for the fraction multiply and reduce block. No dependencies.
package fmr_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int RESULT_W      = 32;
	localparam int EXT_W         = (PROD_W > RESULT_W) ? PROD_W : RESULT_W;
	localparam int CNT_W         = $clog2(PROD_W);

	typedef struct packed {
		logic signed [OPERAND_WIDTH-1:0] first_numerator;
		logic signed [OPERAND_WIDTH-1:0] first_denominator;
		logic signed [OPERAND_WIDTH-1:0] second_numerator;
		logic signed [OPERAND_WIDTH-1:0] second_denominator;
	} operands_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] product_numerator;
		logic signed [RESULT_W-1:0] product_denominator;
		logic                       zero_denominator;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;
		logic mul_num;
		logic mul_den;
		logic gcd_init;
		logic gcd_step;
		logic div_init;
		logic g_one;
		logic div_step;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic gcd_done;
		logic div_last;
	} status_t;

endpackage

### rtl/fmr_datapath.sv
// fmr_datapath: operand registers, shared multiplier, binary gcd unit, two
// restoring dividers and the result register. Depends on fmr_pkg.
module fmr_datapath (
	input  logic               clk,
	input  fmr_pkg::operands_t operands,
	input  fmr_pkg::cmd_t      cmd,
	output fmr_pkg::status_t   status,
	output fmr_pkg::result_t   result
);
	import fmr_pkg::*;

	logic                     n1_neg_q, n2_neg_q, d1_neg_q, d2_neg_q;
	logic [OPERAND_WIDTH-1:0] n1_mag_q, n2_mag_q, d1_mag_q, d2_mag_q;
	logic [PROD_W-1:0]        num_q, den_q;
	logic [PROD_W-1:0]        a_q, b_q;
	logic [CNT_W-1:0]         k_q;
	logic [PROD_W-1:0]        g_q;
	logic [PROD_W-1:0]        qn_q, qd_q;
	logic [PROD_W:0]          rn_q, rd_q;
	logic [CNT_W-1:0]         cnt_q;
	result_t                  result_q;

	logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
	logic [PROD_W-1:0]        mul_p;
	logic [PROD_W-1:0]        a_nx, b_nx;
	logic [CNT_W-1:0]         k_nx;
	logic [PROD_W-1:0]        qn_nx, qd_nx;
	logic [PROD_W:0]          rn_nx, rd_nx;
	logic [EXT_W-1:0]         num_ext, den_ext;
	logic [RESULT_W-1:0]      num_mag32, den_mag32;

	function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
		mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// one restoring step: shift the next dividend bit into the remainder
	function automatic logic [2*PROD_W:0] div_bit(input logic [PROD_W:0] rem,
	                                               input logic [PROD_W-1:0] q,
	                                               input logic [PROD_W-1:0] d);
		logic [PROD_W:0]   r;
		logic              hit;
		r   = {rem[PROD_W-1:0], q[PROD_W-1]};
		hit = (r >= {1'b0, d});
		if (hit) begin
			r = r - {1'b0, d};
		end
		div_bit = {r, q[PROD_W-2:0], hit};
	endfunction

	assign mul_a = cmd.mul_den ? d1_mag_q : n1_mag_q;
	assign mul_b = cmd.mul_den ? d2_mag_q : n2_mag_q;
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		a_nx = a_q;
		b_nx = b_q;
		k_nx = k_q;
		if (!a_q[0] && !b_q[0]) begin
			a_nx = a_q >> 1;
			b_nx = b_q >> 1;
			k_nx = k_q + 1'b1;
		end else if (!a_q[0]) begin
			a_nx = a_q >> 1;
		end else if (!b_q[0]) begin
			b_nx = b_q >> 1;
		end else if (a_q > b_q) begin
			a_nx = (a_q - b_q) >> 1;
		end else begin
			b_nx = (b_q - a_q) >> 1;
		end
	end

	assign {rn_nx, qn_nx} = div_bit(rn_q, qn_q, g_q);
	assign {rd_nx, qd_nx} = div_bit(rd_q, qd_q, g_q);

	assign num_ext   = EXT_W'(qn_q);
	assign den_ext   = EXT_W'(qd_q);
	assign num_mag32 = num_ext[RESULT_W-1:0];
	assign den_mag32 = den_ext[RESULT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			n1_neg_q <= operands.first_numerator[OPERAND_WIDTH-1];
			d1_neg_q <= operands.first_denominator[OPERAND_WIDTH-1];
			n2_neg_q <= operands.second_numerator[OPERAND_WIDTH-1];
			d2_neg_q <= operands.second_denominator[OPERAND_WIDTH-1];
			n1_mag_q <= mag_of(operands.first_numerator);
			d1_mag_q <= mag_of(operands.first_denominator);
			n2_mag_q <= mag_of(operands.second_numerator);
			d2_mag_q <= mag_of(operands.second_denominator);
		end
		if (cmd.mul_num) begin
			num_q <= mul_p;
		end
		if (cmd.mul_den) begin
			den_q <= mul_p;
		end
		if (cmd.gcd_init) begin
			a_q <= num_q;
			b_q <= den_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			a_q <= a_nx;
			b_q <= b_nx;
			k_q <= k_nx;
		end
		if (cmd.div_init) begin
			g_q   <= cmd.g_one ? PROD_W'(1) : (a_q << k_q);
			qn_q  <= num_q;
			qd_q  <= den_q;
			rn_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			qn_q  <= qn_nx;
			qd_q  <= qd_nx;
			rn_q  <= rn_nx;
			rd_q  <= rd_nx;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.out_load) begin
			if (status.den_zero) begin
				result_q.product_numerator   <= '0;
				result_q.product_denominator <= '0;
				result_q.zero_denominator    <= 1'b1;
			end else begin
				result_q.product_numerator   <= (n1_neg_q ^ n2_neg_q) ? -num_mag32 : num_mag32;
				result_q.product_denominator <= (d1_neg_q ^ d2_neg_q) ? -den_mag32 : den_mag32;
				result_q.zero_denominator    <= 1'b0;
			end
		end
	end

	assign status.den_zero = (d1_mag_q == '0) || (d2_mag_q == '0);
	assign status.num_zero = (num_q == '0);
	assign status.gcd_done = (a_q == b_q);
	assign status.div_last = (cnt_q == CNT_W'(PROD_W - 1));
	assign result          = result_q;

endmodule

### rtl/fmr_ctrl.sv
// fmr_ctrl: sequencing state machine and result-valid flag.
// Depends on fmr_pkg; drives fmr_datapath through cmd_t / status_t.
module fmr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             operands_valid,
	output logic             operands_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  fmr_pkg::status_t status,
	output fmr_pkg::cmd_t    cmd
);
	import fmr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MULN = 3'd1;
	localparam logic [2:0] ST_MULD = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_GCD  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0] state_q, state_nx;
	logic       result_valid_q;
	logic       out_free;

	assign out_free       = !result_valid_q || result_ready;
	assign operands_ready = (state_q == ST_IDLE);
	assign result_valid   = result_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (operands_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = ST_MULN;
				end
			end
			ST_MULN: begin
				if (status.den_zero) begin
					state_nx = ST_FIN;
				end else begin
					cmd.mul_num = 1'b1;
					state_nx    = ST_MULD;
				end
			end
			ST_MULD: begin
				cmd.mul_den = 1'b1;
				state_nx    = ST_CHK;
			end
			ST_CHK: begin
				// a zero numerator keeps the divisor at one
				if (status.num_zero) begin
					cmd.div_init = 1'b1;
					cmd.g_one    = 1'b1;
					state_nx     = ST_DIV;
				end else begin
					cmd.gcd_init = 1'b1;
					state_nx     = ST_GCD;
				end
			end
			ST_GCD: begin
				if (status.gcd_done) begin
					cmd.div_init = 1'b1;
					state_nx     = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid_q || result_ready))
		else $error("result register overwritten while pending");

	a_gcd_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD && !status.gcd_done) |=> (state_q == ST_GCD))
		else $error("gcd left before convergence");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && status.div_last) |=> (state_q == ST_FIN))
		else $error("divider did not hand over to finish");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_num, cmd.mul_den, cmd.gcd_step, cmd.div_step, cmd.out_load}))
		else $error("overlapping datapath commands");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(operands_valid && operands_ready) |=> (state_q == ST_MULN))
		else $error("accepted transaction not started");

endmodule

### rtl/fraction_multiply_reduce.sv
// fraction_multiply_reduce: top level, multiplies two fractions and reduces by gcd.
// Depends on fmr_pkg, fmr_ctrl and fmr_datapath.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------
//  operands  | operands_valid / operands_ready | operands (operands_t)
//  result    | result_valid / result_ready     | result (result_t)
//
// One transaction at a time: accept, multiply the numerators, then the denominators,
// a check state, the binary gcd (up to 2*PROD_W steps), PROD_W restoring divide
// steps, then load the result register once it is free.
// A zero input denominator skips to the result after the first multiply slot.
// The result register holds a finished result while the next transaction is taken.
// arst_n clears the controller only; datapath registers carry no reset.
module fraction_multiply_reduce (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operands_valid,
	output logic               operands_ready,
	input  fmr_pkg::operands_t operands,
	output logic               result_valid,
	input  logic               result_ready,
	output fmr_pkg::result_t   result
);
	import fmr_pkg::*;

	cmd_t    cmd;
	status_t status;

	fmr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.operands_valid (operands_valid),
		.operands_ready (operands_ready),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.status         (status),
		.cmd            (cmd)
	);

	fmr_datapath u_datapath (
		.clk      (clk),
		.operands (operands),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

### tb/testbench.sv
// testbench: self-checking bench for fraction_multiply_reduce; predicts each reduced
// product, checks every result transaction in order, and applies random idling.
// Depends on fmr_pkg and the fraction_multiply_reduce RTL.
module testbench;
	import fmr_pkg::*;

	localparam int  CYCLE_LIMIT  = 1500000;
	localparam int  DRAIN_CYCLES = 200;
	localparam logic [OPERAND_WIDTH-1:0] MOST_NEG = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
	localparam logic [OPERAND_WIDTH-1:0] MOST_POS = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      operands_valid = 1'b0;
	logic      operands_ready;
	operands_t operands = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	result_t   result;

	result_t   expected_products[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	int        hold_off_cycles = 0;
	int        stretch_left = 0;
	int        stall_mode = 0;

	fraction_multiply_reduce u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.operands_valid (operands_valid),
		.operands_ready (operands_ready),
		.operands       (operands),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result)
	);

	always #1 clk = ~clk;

	function automatic logic [OPERAND_WIDTH-1:0] magnitude_of(logic [OPERAND_WIDTH-1:0] v);
		return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// gcd over magnitudes; signs reapplied afterwards, no normalisation
	function automatic result_t reduced_product(operands_t op);
		result_t         r;
		longint unsigned num_mag, den_mag, a, b, t;
		logic            num_neg, den_neg;
		r = '0;
		if (op.first_denominator == 0 || op.second_denominator == 0) begin
			r.zero_denominator = 1'b1;
			return r;
		end
		num_mag = 64'(magnitude_of(op.first_numerator)) * 64'(magnitude_of(op.second_numerator));
		den_mag = 64'(magnitude_of(op.first_denominator))
			* 64'(magnitude_of(op.second_denominator));
		if (num_mag != 0) begin
			a = num_mag;
			b = den_mag;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			num_mag = num_mag / a;
			den_mag = den_mag / a;
		end
		num_neg = op.first_numerator[OPERAND_WIDTH-1] ^ op.second_numerator[OPERAND_WIDTH-1];
		den_neg = op.first_denominator[OPERAND_WIDTH-1] ^ op.second_denominator[OPERAND_WIDTH-1];
		r.product_numerator   = RESULT_W'(num_neg ? (64'd0 - num_mag) : num_mag);
		r.product_denominator = RESULT_W'(den_neg ? (64'd0 - den_mag) : den_mag);
		return r;
	endfunction

	task automatic flag_field(input string field, input longint want, input longint got);
		mismatches++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// input capture and result check share one sampling point
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			cycle_count++;
			if (operands_valid && operands_ready)
				expected_products.push_back(reduced_product(operands));
			if (result_valid && result_ready) begin
				if (expected_products.size() == 0) begin
					mismatches++;
					$error("result transaction with nothing outstanding");
				end else begin
					want = expected_products.pop_front();
					if (result.product_numerator !== want.product_numerator)
						flag_field("product_numerator",
							longint'(want.product_numerator),
							longint'(result.product_numerator));
					if (result.product_denominator !== want.product_denominator)
						flag_field("product_denominator",
							longint'(want.product_denominator),
							longint'(result.product_denominator));
					if (result.zero_denominator !== want.zero_denominator)
						flag_field("zero_denominator",
							longint'(want.zero_denominator),
							longint'(result.zero_denominator));
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("FAIL fraction_multiply_reduce");
				$finish;
			end
		end
	end

	// receiver: stretches of always ready, coin-toss ready and mostly stalled
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles = hold_off_cycles - 1;
			result_ready <= 1'b0;
		end else begin
			if (stretch_left == 0) begin
				stall_mode   = $urandom_range(0, 2);
				stretch_left = $urandom_range(10, 200);
			end else begin
				stretch_left--;
			end
			case (stall_mode)
				0:       result_ready <= 1'b1;
				1:       result_ready <= 1'($urandom_range(0, 1));
				default: result_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// bursts of back-to-back transactions separated by random gaps
	task automatic send_operands(input operands_t item);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			operands_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operands_valid <= 1'b1;
		operands       <= item;
		do @(posedge clk); while (!operands_ready);
	endtask

	function automatic logic [OPERAND_WIDTH-1:0] random_operand();
		logic [OPERAND_WIDTH-1:0] v;
		case ($urandom_range(0, 5))
			0, 5: v = OPERAND_WIDTH'($urandom);
			1:    v = OPERAND_WIDTH'(int'($urandom_range(0, 40)) - 20);
			2:    v = OPERAND_WIDTH'(1) << $urandom_range(0, OPERAND_WIDTH - 2);
			// products of small factors share divisors often
			3:    v = OPERAND_WIDTH'($urandom_range(1, 180) * $urandom_range(1, 180));
			default: begin
				case ($urandom_range(0, 4))
					0:       v = MOST_NEG;
					1:       v = MOST_POS;
					2:       v = '0;
					3:       v = OPERAND_WIDTH'(1);
					default: v = '1;
				endcase
			end
		endcase
		if (v != MOST_NEG && $urandom_range(0, 1) == 1)
			v = ~v + 1'b1;
		return v;
	endfunction

	task automatic test_extremes();
		send_operands(operands_t'{MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG});
		send_operands(operands_t'{MOST_POS, 1, MOST_POS, 1});
		send_operands(operands_t'{MOST_NEG, 1, MOST_NEG, 1});
		send_operands(operands_t'{MOST_NEG, 1, MOST_POS, -1});
		send_operands(operands_t'{1, MOST_POS, -1, MOST_NEG});
		// zero numerator product keeps the denominator unreduced
		send_operands(operands_t'{0, MOST_NEG, MOST_POS, 7});
		send_operands(operands_t'{-1, -1, -1, -1});
	endtask

	task automatic test_sign_combinations();
		for (int s = 0; s < 16; s++)
			send_operands(operands_t'{OPERAND_WIDTH'(s[0] ? -6 : 6),
				OPERAND_WIDTH'(s[1] ? -4 : 4),
				OPERAND_WIDTH'(s[2] ? -9 : 9),
				OPERAND_WIDTH'(s[3] ? -10 : 10)});
	endtask

	task automatic test_zero_denominators();
		send_operands(operands_t'{MOST_POS, 0, 3, 5});
		send_operands(operands_t'{MOST_NEG, 9, -1, 0});
		send_operands(operands_t'{0, 0, 0, 0});
	endtask

	// receiver holds off long enough for the result register and the core to fill
	task automatic test_result_backpressure();
		@(negedge clk);
		hold_off_cycles = 1500;
		burst_left = 8;
		for (int i = 0; i < 6; i++)
			send_operands(operands_t'{random_operand(), random_operand(), random_operand(),
				random_operand()});
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++)
			send_operands(operands_t'{random_operand(), random_operand(), random_operand(),
				random_operand()});
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_sign_combinations();
		test_zero_denominators();
		test_result_backpressure();
		test_random(1800);
		@(negedge clk);
		operands_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS fraction_multiply_reduce");
		else
			$display("FAIL fraction_multiply_reduce");
		$finish;
	end

endmodule

### files.f
rtl/fmr_pkg.sv
rtl/fmr_datapath.sv
rtl/fmr_ctrl.sv
rtl/fraction_multiply_reduce.sv
tb/testbench.sv
